// File: rtl/wsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Types and fixed widths shared by the world-to-screen projection pipeline.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int COORD_BITS = 20;
  localparam int COEF_BITS  = 16;
  localparam int SIZE_BITS  = 13;
  localparam int TAN_BITS   = 16;
  localparam int ORIGIN_BITS = 3 * COORD_BITS;
  localparam int ROW_BITS   = 3 * COEF_BITS;
  localparam int CFG_BITS   = ORIGIN_BITS;
  localparam int IDX_BITS   = 3;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + COEF_BITS;
  localparam int DOT_BITS   = PROD_BITS + 2;
  localparam int MAG_BITS   = DOT_BITS;
  localparam int DEPTH_FRAC = 4 + COEF_BITS - 2;
  localparam longint THRESH = ((64'd1 << DEPTH_FRAC) + 64'd99) / 64'd100;

  // quotient bits: anything larger saturates the screen coordinate anyway
  localparam int QUO_BITS   = COORD_BITS + 1;

  // pipeline depth: dot products, then the per-axis scale, divide and offset stages
  localparam int DOT_STAGES  = 3;
  localparam int AXIS_STAGES = QUO_BITS + 5;
  localparam int NUM_STAGES  = DOT_STAGES + AXIS_STAGES;

  localparam logic [IDX_BITS-1:0] REG_ORIGIN  = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_FORWARD = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_RIGHT   = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_UP      = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_WIDTH   = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_HEIGHT  = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_TAN_X   = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_TAN_Y   = 3'd7;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic                         in_front;
    logic signed [COORD_BITS-1:0] screen_x;
    logic signed [COORD_BITS-1:0] screen_y;
  } screen_t;

endpackage

// File: rtl/wsp_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_dot
// Origin subtraction and the three view-axis dot products, three stages.
// ----------------------------------------------------------------------------
module wsp_dot (
  input  logic                                 clk,
  input  logic [wsp_pkg::DOT_STAGES-1:0]       en,
  input  wsp_pkg::point_t                      point,
  input  logic [wsp_pkg::ORIGIN_BITS-1:0]      origin,
  input  logic [wsp_pkg::ROW_BITS-1:0]         fwd_row,
  input  logic [wsp_pkg::ROW_BITS-1:0]         rgt_row,
  input  logic [wsp_pkg::ROW_BITS-1:0]         up_row,
  output logic signed [wsp_pkg::DOT_BITS-1:0]  depth,
  output logic signed [wsp_pkg::DOT_BITS-1:0]  lat_x,
  output logic signed [wsp_pkg::DOT_BITS-1:0]  lat_y
);
  import wsp_pkg::*;

  logic signed [COORD_BITS-1:0] pt [3];
  logic signed [DIFF_BITS-1:0]  diff_next [3];
  logic signed [DIFF_BITS-1:0]  diff [3];
  logic signed [PROD_BITS-1:0]  prod_next [9];
  logic signed [PROD_BITS-1:0]  prod [9];
  logic [ROW_BITS-1:0]          rows [3];

  assign pt[0] = point.point_x;
  assign pt[1] = point.point_y;
  assign pt[2] = point.point_z;
  assign rows[0] = fwd_row;
  assign rows[1] = rgt_row;
  assign rows[2] = up_row;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_next[k] = DIFF_BITS'(pt[k]) -
                     DIFF_BITS'(signed'(origin[k*COORD_BITS +: COORD_BITS]));
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_next[r*3+k] = PROD_BITS'(diff[k] *
                           signed'(rows[r][k*COEF_BITS +: COEF_BITS]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) diff <= diff_next;
    if (en[1]) prod <= prod_next;
    if (en[2]) begin
      depth <= DOT_BITS'(prod[0]) + DOT_BITS'(prod[1]) + DOT_BITS'(prod[2]);
      lat_x <= DOT_BITS'(prod[3]) + DOT_BITS'(prod[4]) + DOT_BITS'(prod[5]);
      lat_y <= DOT_BITS'(prod[6]) + DOT_BITS'(prod[7]) + DOT_BITS'(prod[8]);
    end
  end

endmodule

// File: rtl/wsp_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_axis
// One screen axis: scale, pipelined restoring divide, offset and saturate.
// ----------------------------------------------------------------------------
module wsp_axis (
  input  logic                                  clk,
  input  logic [wsp_pkg::AXIS_STAGES-1:0]       en,
  input  logic signed [wsp_pkg::DOT_BITS-1:0]   lat,
  input  logic signed [wsp_pkg::DOT_BITS-1:0]   depth,
  input  logic [wsp_pkg::SIZE_BITS-1:0]         size,
  input  logic [wsp_pkg::TAN_BITS-1:0]          tan,
  output logic signed [wsp_pkg::COORD_BITS-1:0] coord
);
  import wsp_pkg::*;

  localparam int H     = (MAG_BITS + 1) / 2;
  localparam int HI    = MAG_BITS - H;
  localparam int NUM_W = SIZE_BITS + MAG_BITS;
  localparam int DEN_W = TAN_BITS + MAG_BITS;
  localparam int NP_W  = NUM_W + 17;
  localparam int DP_W  = DEN_W + 1;
  localparam int XW    = DP_W + QUO_BITS;
  localparam int CW    = ((NP_W > XW) ? NP_W : XW) + 1;
  localparam int VW    = QUO_BITS + 2;
  localparam logic signed [VW-1:0] LIM_HI = VW'((64'd1 << (COORD_BITS - 1)) - 64'd1);
  localparam logic signed [VW-1:0] LIM_LO = -VW'(64'd1 << (COORD_BITS - 1));

  // stage a0: magnitude and partial products
  logic [MAG_BITS-1:0]      mag;
  logic [MAG_BITS-1:0]      dep;
  logic [TAN_BITS-1:0]      tan_e;
  logic [SIZE_BITS+H-1:0]   pn_lo;
  logic [SIZE_BITS+HI-1:0]  pn_hi;
  logic [TAN_BITS+H-1:0]    pd_lo;
  logic [TAN_BITS+HI-1:0]   pd_hi;
  logic                     neg0;
  // stage a1
  logic [NUM_W-1:0]         num;
  logic [DEN_W-1:0]         den;
  logic                     neg1;
  // stage a2
  logic [NP_W-1:0]          np;
  logic [DP_W-1:0]          dp2;
  logic                     neg2;
  // divide chain, index 0 is the entry
  logic [XW-1:0]            rem_w [QUO_BITS+1];
  logic [QUO_BITS-1:0]      quo_w [QUO_BITS+1];
  logic [DP_W-1:0]          dp_w  [QUO_BITS+1];
  logic                     ovf_w [QUO_BITS+1];
  logic                     neg_w [QUO_BITS+1];
  // final
  logic [QUO_BITS-1:0]      qv;
  logic signed [VW-1:0]     v;

  assign tan_e = (tan == '0) ? TAN_BITS'(1) : tan;
  assign mag   = lat[DOT_BITS-1] ? MAG_BITS'(-lat) : MAG_BITS'(lat);
  assign dep   = MAG_BITS'(depth);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pn_lo <= size * mag[H-1:0];
      pn_hi <= size * mag[MAG_BITS-1:H];
      pd_lo <= tan_e * dep[H-1:0];
      pd_hi <= tan_e * dep[MAG_BITS-1:H];
      neg0  <= lat[DOT_BITS-1];
    end
    if (en[1]) begin
      num  <= NUM_W'(pn_lo) + (NUM_W'(pn_hi) << H);
      den  <= DEN_W'(pd_lo) + (DEN_W'(pd_hi) << H);
      neg1 <= neg0;
    end
    if (en[2]) begin
      // rounded quotient: (2*num*2^15 + den) / (2*den)
      np   <= (NP_W'(num) << 16) + NP_W'(den);
      dp2  <= {den, 1'b0};
      neg2 <= neg1;
    end
    if (en[3]) begin
      ovf_w[0] <= (CW'(np) >= (CW'(dp2) << QUO_BITS));
      rem_w[0] <= XW'(np);
      quo_w[0] <= '0;
      dp_w[0]  <= dp2;
      neg_w[0] <= neg2;
    end
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    localparam int B = QUO_BITS - 1 - j;
    logic [XW-1:0] sub;
    logic          take;
    assign sub  = XW'(dp_w[j]) << B;
    assign take = (rem_w[j] >= sub);
    always_ff @(posedge clk) begin
      if (en[4+j]) begin
        rem_w[j+1] <= take ? (rem_w[j] - sub) : rem_w[j];
        quo_w[j+1] <= quo_w[j] | (QUO_BITS'(take) << B);
        dp_w[j+1]  <= dp_w[j];
        ovf_w[j+1] <= ovf_w[j];
        neg_w[j+1] <= neg_w[j];
      end
    end
  end

  assign qv = ovf_w[QUO_BITS] ? '1 : quo_w[QUO_BITS];

  always_comb begin
    if (neg_w[QUO_BITS]) begin
      v = signed'(VW'({size, 3'b000})) + signed'(VW'(qv));
    end else begin
      v = signed'(VW'({size, 3'b000})) - signed'(VW'(qv));
    end
  end

  always_ff @(posedge clk) begin
    if (en[AXIS_STAGES-1]) begin
      if (v > LIM_HI)      coord <= COORD_BITS'(LIM_HI);
      else if (v < LIM_LO) coord <= COORD_BITS'(LIM_LO);
      else                 coord <= COORD_BITS'(v);
    end
  end

endmodule

// File: rtl/world_to_screen_projection_core.sv
`timescale 1ns / 1ps
// Pipeline: 3 dot-product stages, 4 scale stages, 21 divide stages and
//   1 offset/saturate stage from an accepted request to its result.
// Throughput: one point per cycle; a stalled result holds only the stages
//   behind it that are full, bubbles are squeezed out.
// Reset: clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
// world_to_screen_projection_core
// Perspective projection of a world point onto screen pixels.
// ----------------------------------------------------------------------------
module world_to_screen_projection_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_en,
  input  logic [wsp_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [wsp_pkg::CFG_BITS-1:0]   cfg_data,
  input  logic                           point_valid,
  output logic                           point_stall,
  input  wsp_pkg::point_t                point,
  output logic                           result_valid,
  input  logic                           result_stall,
  output wsp_pkg::screen_t               result
);
  import wsp_pkg::*;

  logic [ORIGIN_BITS-1:0] origin;
  logic [ROW_BITS-1:0]    fwd_row;
  logic [ROW_BITS-1:0]    rgt_row;
  logic [ROW_BITS-1:0]    up_row;
  logic [SIZE_BITS-1:0]   width;
  logic [SIZE_BITS-1:0]   height;
  logic [TAN_BITS-1:0]    tan_x;
  logic [TAN_BITS-1:0]    tan_y;

  logic [NUM_STAGES-1:0]  vld;
  logic [NUM_STAGES-1:0]  en;
  logic [NUM_STAGES-1:DOT_STAGES] front;

  logic signed [DOT_BITS-1:0]   depth;
  logic signed [DOT_BITS-1:0]   lat_x;
  logic signed [DOT_BITS-1:0]   lat_y;
  logic signed [COORD_BITS-1:0] sx;
  logic signed [COORD_BITS-1:0] sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin  <= '0;
      fwd_row <= '0;
      rgt_row <= '0;
      up_row  <= '0;
      width   <= SIZE_BITS'(640);
      height  <= SIZE_BITS'(480);
      tan_x   <= TAN_BITS'(4096);
      tan_y   <= TAN_BITS'(4096);
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_ORIGIN:  origin  <= cfg_data[ORIGIN_BITS-1:0];
        REG_FORWARD: fwd_row <= cfg_data[ROW_BITS-1:0];
        REG_RIGHT:   rgt_row <= cfg_data[ROW_BITS-1:0];
        REG_UP:      up_row  <= cfg_data[ROW_BITS-1:0];
        REG_WIDTH:   width   <= cfg_data[SIZE_BITS-1:0];
        REG_HEIGHT:  height  <= cfg_data[SIZE_BITS-1:0];
        REG_TAN_X:   tan_x   <= cfg_data[TAN_BITS-1:0];
        REG_TAN_Y:   tan_y   <= cfg_data[TAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !result_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign point_stall  = !en[0];
  assign result_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= point_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // carry the depth test alongside the divide
  always_ff @(posedge clk) begin
    if (en[DOT_STAGES]) front[DOT_STAGES] <= (64'(depth) >= 64'(THRESH));
    for (int k = DOT_STAGES + 1; k < NUM_STAGES; k++) begin
      if (en[k]) front[k] <= front[k-1];
    end
  end

  wsp_dot u_dot (
    .clk     (clk),
    .en      (en[DOT_STAGES-1:0]),
    .point   (point),
    .origin  (origin),
    .fwd_row (fwd_row),
    .rgt_row (rgt_row),
    .up_row  (up_row),
    .depth   (depth),
    .lat_x   (lat_x),
    .lat_y   (lat_y)
  );

  wsp_axis u_axis_x (
    .clk   (clk),
    .en    (en[NUM_STAGES-1:DOT_STAGES]),
    .lat   (lat_x),
    .depth (depth),
    .size  (width),
    .tan   (tan_x),
    .coord (sx)
  );

  wsp_axis u_axis_y (
    .clk   (clk),
    .en    (en[NUM_STAGES-1:DOT_STAGES]),
    .lat   (lat_y),
    .depth (depth),
    .size  (height),
    .tan   (tan_y),
    .coord (sy)
  );

  // behind the camera: drop the screen position
  assign result.in_front = front[NUM_STAGES-1];
  assign result.screen_x = front[NUM_STAGES-1] ? sx : '0;
  assign result.screen_y = front[NUM_STAGES-1] ? sy : '0;

endmodule
